[src/pid_controller_filtered_derivative_core_assert.svh]
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_CORE_ASSERT_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_CORE_ASSERT_SVH

// implication checked in the same cycle
`define PIDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidf assertion failed");

// implication checked in the following cycle
`define PIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidf assertion failed");

`endif

[src/pidf_pkg.sv]
package pidf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_W      = 32;
  localparam int MAX_DRIVE_W = SAMPLE_W - 1;
  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int PROD_W      = COEF_W + ERR_W - 1;
  // five products summed
  localparam int ACC_W       = PROD_W + 3;
  localparam int SHIFT_W     = ACC_W - FRAC_BITS;
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_ERR0 = 3'd0,
    REG_COEF_ERR1 = 3'd1,
    REG_COEF_ERR2 = 3'd2,
    REG_COEF_OUT1 = 3'd3,
    REG_COEF_OUT2 = 3'd4,
    REG_MAX_DRIVE = 3'd5
  } pidf_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] err0;
    logic signed [COEF_W-1:0] err1;
    logic signed [COEF_W-1:0] err2;
  } pidf_err_coef_t;

endpackage

[src/pid_controller_filtered_derivative_core.sv]
// Discrete PID controller with filtered derivative in second-order difference form. Each
// input word carries a reference and a measurement; the result word carries the drive
// c_out1*d1 + c_out2*d2 + c_err0*e0 + c_err1*e1 + c_err2*e2, floored by 16 fraction bits
// and clamped to +/- max_drive, plus a flag that is set when the clamp acted. One word is
// accepted per clock, sustained, while out_tready does not hold the output back. The error
// products are computed in a three-stage pipeline ahead of the drive feedback; the rate is
// set by the output stage, where the product of c_out1 with the drive just produced, the
// accumulate and the clamp close the feedback loop through the registered drive alone.
// Coefficients are signed Q15.16 and reset to zero, max_drive resets to 32767, and the
// histories reset to zero. Write configuration only while no word is in flight.
`include "pid_controller_filtered_derivative_core_assert.svh"

module pid_controller_filtered_derivative_core
  import pidf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*SAMPLE_W-1:0] in_tdata,   // reference, measured
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // drive
  output logic                  out_tuser,  // limited
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  logic signed [COEF_W-1:0]   coef_err0_r, coef_err1_r, coef_err2_r;
  logic signed [COEF_W-1:0]   coef_out1_r, coef_out2_r;
  logic [MAX_DRIVE_W-1:0]     max_drive_r;
  pidf_err_coef_t             err_coef;

  logic                       sum_valid, sum_ready, fire;
  logic signed [ACC_W-1:0]    err_sum;

  logic signed [SAMPLE_W-1:0] dh0_r, dh1_r, dh0_nxt, dh1_nxt;
  logic signed [PROD_W-1:0]   po1, po2_r, po2_nxt;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SHIFT_W-1:0]  v, lim_pos, lim_neg;
  logic signed [SAMPLE_W-1:0] drive_nxt;
  logic                       limited_nxt;

  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_drive_r;
  logic                       out_limited_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_err0_r <= '0;
      coef_err1_r <= '0;
      coef_err2_r <= '0;
      coef_out1_r <= '0;
      coef_out2_r <= '0;
      max_drive_r <= '1;
    end else if (cfg_we) begin
      case (pidf_reg_t'(cfg_addr))
        REG_COEF_ERR0: coef_err0_r <= cfg_wdata;
        REG_COEF_ERR1: coef_err1_r <= cfg_wdata;
        REG_COEF_ERR2: coef_err2_r <= cfg_wdata;
        REG_COEF_OUT1: coef_out1_r <= cfg_wdata;
        REG_COEF_OUT2: coef_out2_r <= cfg_wdata;
        REG_MAX_DRIVE: max_drive_r <= cfg_wdata[MAX_DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign err_coef.err0 = coef_err0_r;
  assign err_coef.err1 = coef_err1_r;
  assign err_coef.err2 = coef_err2_r;

  pidf_err_path u_err_path (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .reference (in_tdata[SAMPLE_W-1:0]),
    .measured  (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .coef      (err_coef),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .err_sum   (err_sum)
  );

  assign sum_ready = !out_valid_r || out_tready;
  assign fire      = sum_valid && sum_ready;

  // feedback stage
  assign po1     = PROD_W'(coef_out1_r) * PROD_W'(dh0_r);
  assign acc     = ACC_W'(po1) + ACC_W'(po2_r) + err_sum;
  assign v       = acc[ACC_W-1:FRAC_BITS];
  assign lim_pos = SHIFT_W'($signed({1'b0, max_drive_r}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (v > lim_pos) begin
      drive_nxt   = lim_pos[SAMPLE_W-1:0];
      limited_nxt = 1'b1;
    end else if (v < lim_neg) begin
      drive_nxt   = lim_neg[SAMPLE_W-1:0];
      limited_nxt = 1'b1;
    end else begin
      drive_nxt   = v[SAMPLE_W-1:0];
      limited_nxt = 1'b0;
    end
  end

  assign dh0_nxt = fire ? drive_nxt : dh0_r;
  assign dh1_nxt = fire ? dh0_r : dh1_r;
  // second drive term registered in advance from the value dh1 is about to hold
  assign po2_nxt = PROD_W'(coef_out2_r) * PROD_W'(dh1_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dh0_r       <= '0;
      dh1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dh0_r <= dh0_nxt;
      dh1_r <= dh1_nxt;
      if (sum_ready) begin
        out_valid_r <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    po2_r <= po2_nxt;
    if (fire) begin
      out_drive_r   <= drive_nxt;
      out_limited_r <= limited_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_limited_r;

  `PIDF_ASSERT_NEXT(a_dh_tracks_out, clk, rst_n, fire, dh0_r == out_drive_r && out_valid_r)
  `PIDF_ASSERT_NEXT(a_dh_shift, clk, rst_n, fire, dh1_r == $past(dh0_r))
  `PIDF_ASSERT_NEXT(a_dh_hold, clk, rst_n, !sum_ready, $stable(dh0_r) && $stable(dh1_r))

endmodule

[src/pidf_err_path.sv]
`include "pid_controller_filtered_derivative_core_assert.svh"

module pidf_err_path
  import pidf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] reference,
  input  logic signed [SAMPLE_W-1:0] measured,
  input  pidf_err_coef_t             coef,
  output logic                       sum_valid,
  input  logic                       sum_ready,
  output logic signed [ACC_W-1:0]    err_sum
);

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  logic                     s1_ready, s2_ready, s3_ready;
  logic                     s2_load;
  logic signed [ERR_W-1:0]  s1_err_r, s1_err_nxt;
  logic signed [ERR_W-1:0]  eh0_r, eh1_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [ACC_W-1:0]  sum_r, sum_nxt;

  assign s3_ready = !s3_valid_r || sum_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  assign s1_err_nxt = ERR_W'(reference) - ERR_W'(measured);

  assign p0_nxt = PROD_W'($signed(coef.err0)) * PROD_W'(s1_err_r);
  assign p1_nxt = PROD_W'($signed(coef.err1)) * PROD_W'(eh0_r);
  assign p2_nxt = PROD_W'($signed(coef.err2)) * PROD_W'(eh1_r);

  assign sum_nxt = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      eh0_r      <= '0;
      eh1_r      <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s2_load) begin
        eh0_r <= s1_err_r;
        eh1_r <= eh0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_err_r <= s1_err_nxt;
    end
    if (s2_load) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (s3_ready) begin
      sum_r <= sum_nxt;
    end
  end

  assign in_ready  = s1_ready;
  assign sum_valid = s3_valid_r;
  assign err_sum   = sum_r;

  `PIDF_ASSERT_NEXT(a_eh_shift, clk, rst_n, s2_load, eh1_r == $past(eh0_r))
  `PIDF_ASSERT_NEXT(a_eh_load, clk, rst_n, s2_load, eh0_r == $past(s1_err_r))
  `PIDF_ASSERT_NEXT(a_sum_hold, clk, rst_n, s3_valid_r && !sum_ready,
                    s3_valid_r && $stable(sum_r))

endmodule

[tb/pid_controller_filtered_derivative_core_checker.sv]
module pid_controller_filtered_derivative_core_checker
  import pidf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [2*SAMPLE_W-1:0] in_tdata,   // reference, measured
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [SAMPLE_W-1:0]   out_tdata,  // drive
  input  logic                  out_tuser,  // limited
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       limited;
  } drive_word_t;

  logic signed [COEF_W-1:0]   gain_err0, gain_err1, gain_err2, gain_out1, gain_out2;
  logic [MAX_DRIVE_W-1:0]     drive_limit;
  logic signed [ERR_W-1:0]    err_hist [2];
  logic signed [SAMPLE_W-1:0] drive_hist [2];
  drive_word_t                expected_drives [$];
  int                         fails = 0;
  int                         checked = 0;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  // one control step: filtered pid difference equation, floor, clamp, history shift
  function automatic drive_word_t step_controller(input logic [SAMPLE_W-1:0] setpoint,
                                                  input logic [SAMPLE_W-1:0] measured);
    logic signed [ERR_W-1:0] err_now;
    longint                  acc;
    longint                  level;
    longint                  lim;
    drive_word_t             res;
    err_now = $signed({setpoint[SAMPLE_W-1], setpoint})
            - $signed({measured[SAMPLE_W-1], measured});
    acc = longint'(gain_out1) * longint'(drive_hist[0])
        + longint'(gain_out2) * longint'(drive_hist[1])
        + longint'(gain_err0) * longint'(err_now)
        + longint'(gain_err1) * longint'(err_hist[0])
        + longint'(gain_err2) * longint'(err_hist[1]);
    level = acc >>> FRAC_BITS;
    lim = longint'(drive_limit);
    res.limited = 1'b0;
    if (level > lim) begin
      level = lim;
      res.limited = 1'b1;
    end else if (level < -lim) begin
      level = -lim;
      res.limited = 1'b1;
    end
    res.drive = SAMPLE_W'(level);
    err_hist[1]   = err_hist[0];
    err_hist[0]   = err_now;
    drive_hist[1] = drive_hist[0];
    drive_hist[0] = res.drive;
    return res;
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    if (!rst_n) begin
      gain_err0     = '0;
      gain_err1     = '0;
      gain_err2     = '0;
      gain_out1     = '0;
      gain_out2     = '0;
      drive_limit   = '1;
      err_hist[0]   = '0;
      err_hist[1]   = '0;
      drive_hist[0] = '0;
      drive_hist[1] = '0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (pidf_reg_t'(cfg_addr))
          REG_COEF_ERR0: gain_err0 = cfg_wdata;
          REG_COEF_ERR1: gain_err1 = cfg_wdata;
          REG_COEF_ERR2: gain_err2 = cfg_wdata;
          REG_COEF_OUT1: gain_out1 = cfg_wdata;
          REG_COEF_OUT2: gain_out2 = cfg_wdata;
          REG_MAX_DRIVE: drive_limit = cfg_wdata[MAX_DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_drives.push_back(step_controller(in_tdata[SAMPLE_W-1:0],
                                                  in_tdata[2*SAMPLE_W-1:SAMPLE_W]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("drive word %0d with none expected", $signed(out_tdata)));
        end else begin
          want = expected_drives.pop_front();
          checked++;
          if (out_tdata !== want.drive) begin
            report_mismatch($sformatf("drive %0d, expected %0d",
                                      $signed(out_tdata), want.drive));
          end
          if (out_tuser !== want.limited) begin
            report_mismatch($sformatf("limited %b, expected %b (drive %0d)",
                                      out_tuser, want.limited, want.drive));
          end
        end
      end
    end
    pending_count <= expected_drives.size();
    fail_count    <= fails;
    checked_count <= checked;
  end

endmodule

[tb/pid_controller_filtered_derivative_core_tb.sv]
module pid_controller_filtered_derivative_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 10;
  localparam int RUN_LIMIT       = 300000;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 160;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [2*SAMPLE_W-1:0] in_tdata;   // reference, measured
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SAMPLE_W-1:0]   out_tdata;  // drive
  logic                  out_tuser;  // limited
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [COEF_W-1:0]     cfg_wdata;

  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   cycle_cnt = 0;
  int   words_sent = 0;
  int   settings_loaded = 0;

  pid_controller_filtered_derivative_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pid_controller_filtered_derivative_core_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("run stopped at cycle limit with %0d drives still awaited", pending_count);
    $display("FAIL pid_controller_filtered_derivative_core");
    $finish;
  end

  // output side: random back-pressure, or a long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] setpoint,
                           input logic [SAMPLE_W-1:0] measured);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {measured, setpoint};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stop sending and wait for every drive word to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_gains(input logic [COEF_W-1:0] e0, e1, e2, o1, o2, lim);
    settle();
    write_reg(REG_COEF_ERR0, e0);
    write_reg(REG_COEF_ERR1, e1);
    write_reg(REG_COEF_ERR2, e2);
    write_reg(REG_COEF_OUT1, o1);
    write_reg(REG_COEF_OUT2, o2);
    write_reg(REG_MAX_DRIVE, lim);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic random_gains(input int kind);
    logic [COEF_W-1:0] g [5];
    logic [COEF_W-1:0] lim;
    int                kp, ki, kd, a;
    kp = $urandom_range(0, 4 << FRAC_BITS);
    ki = $urandom_range(0, 1 << (FRAC_BITS - 4));
    kd = $urandom_range(0, 2 << FRAC_BITS);
    a  = $urandom_range(0, (1 << FRAC_BITS) - 1);
    case (kind)
      0: begin
        // realistic controller: integrator plus filtered derivative pole
        g[0] = COEF_W'(kp + ki + kd);
        g[1] = COEF_W'(-(kp + 2 * kd));
        g[2] = COEF_W'(kd);
        g[3] = COEF_W'((1 << FRAC_BITS) + a);
        g[4] = COEF_W'(-a);
        lim  = $urandom_range(1000, 32767);
      end
      1: begin
        for (int i = 0; i < 5; i++) g[i] = $urandom;
        lim = $urandom;
      end
      2: begin
        for (int i = 0; i < 5; i++) begin
          case ($urandom_range(3))
            0: g[i] = 32'h7FFF_FFFF;
            1: g[i] = 32'h8000_0000;
            2: g[i] = 32'h0000_0000;
            default: g[i] = 32'hFFFF_FFFF;
          endcase
        end
        lim = $urandom_range(1) ? 32'd32767 : 32'd0;
      end
      default: begin
        for (int i = 0; i < 5; i++) begin
          a = $urandom_range(0, 8191);
          g[i] = COEF_W'(a - 4096);
        end
        lim = 32'd32767;
      end
    endcase
    load_gains(g[0], g[1], g[2], g[3], g[4], lim);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] centre);
    if ($urandom_range(3) == 0) return SAMPLE_W'($urandom);
    return centre + SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] centre;
    int                  mode;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: everything drives zero, even at the widest error
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h0000, 16'h0000);

    // unity proportional gain against a limit of 100: exact limit and one past it
    load_gains(32'h0001_0000, 0, 0, 0, 0, 32'd100);
    send_word(16'd100, 16'd0);
    send_word(16'd101, 16'd0);
    send_word(16'd0, 16'd100);
    send_word(16'd0, 16'd101);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);

    // half gain: negative odd sums round towards minus infinity
    load_gains(32'h0000_8000, 0, 0, 0, 0, 32'd32767);
    send_word(16'd0, 16'd1);
    send_word(16'd1, 16'd0);
    send_word(16'd0, 16'd3);

    // zero limit: only a zero sum is not flagged
    load_gains(32'h0001_0000, 0, 0, 0, 0, 32'd0);
    send_word(16'd0, 16'd0);
    send_word(16'd7, 16'd0);
    send_word(16'd0, 16'd7);

    // largest coefficients of alternating sign across the taps
    load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0000_7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h1234, 16'h1234);

    // output held off for a long stretch while input keeps coming
    random_gains(0);
    gap_pct = 0;
    stall_pct <= 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    centre = SAMPLE_W'($urandom);
    for (int n = 0; n < 40; n++) send_word(pick_sample(centre), pick_sample(centre));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_gains(p % 4);
      mode = (p + p / 4) % 4;
      case (mode)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 56; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 56; end
        default: begin gap_pct = 28; stall_pct <= 28; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 20 == 0) centre = SAMPLE_W'($urandom);
        send_word(pick_sample(centre), pick_sample(centre));
      end
    end

    settle();
    $display("%0d words sent under %0d gain settings, %0d drive words checked",
             words_sent, settings_loaded, checked_count);
    $display("covered clamp edges, zero limit, floor rounding, extreme gains, long hold-off");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS pid_controller_filtered_derivative_core");
    end else begin
      $display("FAIL pid_controller_filtered_derivative_core");
    end
    $finish;
  end

endmodule

[pid_controller_filtered_derivative_core.f]
+incdir+src
src/pidf_pkg.sv
src/pidf_err_path.sv
src/pid_controller_filtered_derivative_core.sv
tb/pid_controller_filtered_derivative_core_checker.sv
tb/pid_controller_filtered_derivative_core_tb.sv
